>>> rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Types and constants shared by the tile/sprite scanline renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

  localparam int VRAM_AW = 13;
  localparam int VRAM_BYTES = 8192;

  localparam logic [1:0] FN_VRAM_WR = 2'd0;
  localparam logic [1:0] FN_OAM_WR  = 2'd1;
  localparam logic [1:0] FN_LINE    = 2'd2;
  localparam logic [1:0] FN_PIXEL   = 2'd3;

  localparam logic [2:0] REG_LCDC = 3'd0;
  localparam logic [2:0] REG_SCY  = 3'd1;
  localparam logic [2:0] REG_SCX  = 3'd2;
  localparam logic [2:0] REG_WY   = 3'd3;
  localparam logic [2:0] REG_WX   = 3'd4;
  localparam logic [2:0] REG_BGP  = 3'd5;
  localparam logic [2:0] REG_OBP0 = 3'd6;
  localparam logic [2:0] REG_OBP1 = 3'd7;

  localparam logic [VRAM_AW-1:0] MAP0_BASE     = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP1_BASE     = 13'h1c00;
  localparam logic [VRAM_AW-1:0] SIGNED_BASE   = 13'h0800;
  localparam logic [VRAM_AW-1:0] OBJ_BANK_BASE = 13'h1000;
  localparam logic [7:0]         TILE_FLIP     = 8'd128;
  localparam logic [8:0]         OBJ_Y_OFS     = 9'd16;
  localparam logic [8:0]         OBJ_X_OFS     = 9'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CAP,
    ST_MAP,
    ST_TLO,
    ST_THI,
    ST_BG,
    ST_OBJ,
    ST_OLO,
    ST_OHI,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/tsr_if.sv
// ----------------------------------------------------------------------------
// tsr_if
// Valid/ready channels for renderer requests and rendered pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [12:0] mem_address;
  logic [7:0]  write_data;
  logic [7:0]  line;
  logic [7:0]  column;

  modport source (output valid, func, mem_address, write_data, line, column, input ready);
  modport sink   (input valid, func, mem_address, write_data, line, column, output ready);
endinterface

interface tsr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] shade;
  logic [7:0] pixel_column;
  logic       from_object;

  modport source (output valid, shade, pixel_column, from_object, input ready);
  modport sink   (input valid, shade, pixel_column, from_object, output ready);
endinterface

`default_nettype wire

>>> rtl/tile_sprite_scanline_renderer.sv
// ----------------------------------------------------------------------------
// tile_sprite_scanline_renderer
// Tile-map background/window and 8x8 object renderer, at most one pixel per request.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A video or object byte write is done as
// it is taken. A start line, when LCDC bit 1 is set, scans the object table
// with a read state and a capture state per byte (one read port), ending
// early once the line's object list is full. A render pixel fetches its map
// entry and tile row, then tries the kept objects in turn until one that
// covers the column gives an opaque color, fetching each covering object's
// tile row over the single video memory read port. The result sits in an
// output register, so the next request is taken while it waits.
`default_nettype none

module tile_sprite_scanline_renderer
  import tsr_pkg::*;
#(
  parameter int OBJECT_BYTES     = 160,
  parameter int MAX_LINE_OBJECTS = 10,
  parameter int LINE_WIDTH       = 160
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tsr_req_if.sink          req,
  tsr_rsp_if.source        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int NUM_OBJ = OBJECT_BYTES / 4;
  localparam int OAW     = $clog2(OBJECT_BYTES);
  localparam int OIW     = (NUM_OBJ > 1) ? $clog2(NUM_OBJ) : 1;
  localparam int CW      = $clog2(MAX_LINE_OBJECTS + 1);
  localparam int LIW     = (MAX_LINE_OBJECTS > 1) ? $clog2(MAX_LINE_OBJECTS) : 1;

  // registers
  logic [7:0] lcdc, scy, scx, wy, wx, bgp, obp0, obp1;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcdc <= '0; scy <= '0; scx <= '0; wy <= '0;
      wx <= '0; bgp <= '0; obp0 <= '0; obp1 <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_LCDC: lcdc <= pwdata[7:0];
        REG_SCY:  scy  <= pwdata[7:0];
        REG_SCX:  scx  <= pwdata[7:0];
        REG_WY:   wy   <= pwdata[7:0];
        REG_WX:   wx   <= pwdata[7:0];
        REG_BGP:  bgp  <= pwdata[7:0];
        REG_OBP0: obp0 <= pwdata[7:0];
        REG_OBP1: obp1 <= pwdata[7:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_LCDC: prdata[7:0] = lcdc;
      REG_SCY:  prdata[7:0] = scy;
      REG_SCX:  prdata[7:0] = scx;
      REG_WY:   prdata[7:0] = wy;
      REG_WX:   prdata[7:0] = wx;
      REG_BGP:  prdata[7:0] = bgp;
      REG_OBP0: prdata[7:0] = obp0;
      REG_OBP1: prdata[7:0] = obp1;
      default:  prdata = '0;
    endcase
  end

  // state
  state_t state, state_next;
  logic   accept;

  logic [7:0]         cur_line;
  logic               win_act;
  logic [CW-1:0]      obj_cnt;
  logic [31:0]        line_objs [MAX_LINE_OBJECTS];
  logic [OIW-1:0]     scan_idx;
  logic [1:0]         scan_byte;
  logic [23:0]        scan_word;
  logic [CW-1:0]      obj_idx;

  logic [7:0]         px, xpos, ypos;
  logic [VRAM_AW-1:0] row_addr;
  logic [7:0]         lo_byte;
  logic [1:0]         bg;
  logic [2:0]         obj_relx;
  logic [7:0]         obj_attr;

  logic               out_valid;
  logic [1:0]         out_shade;
  logic [7:0]         out_col;
  logic               out_obj;
  logic [1:0]         res_shade;
  logic               res_obj;

  // memories
  logic [VRAM_AW-1:0] vram_raddr;
  logic [7:0]         vram_rdata;
  logic [OAW-1:0]     oam_raddr;
  logic [7:0]         oam_rdata;
  logic               oam_we;

  assign oam_we = accept && (req.func == FN_OAM_WR)
                  && ({3'b0, req.mem_address} < 16'(OBJECT_BYTES));
  assign oam_raddr = OAW'({scan_idx, scan_byte});

  tsr_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram (
    .clk   (clk),
    .we    (accept && (req.func == FN_VRAM_WR)),
    .waddr (req.mem_address),
    .wdata (req.write_data),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  tsr_ram #(.WIDTH(8), .DEPTH(OBJECT_BYTES)) u_oam (
    .clk   (clk),
    .we    (oam_we),
    .waddr (req.mem_address[OAW-1:0]),
    .wdata (req.write_data),
    .raddr (oam_raddr),
    .rdata (oam_rdata)
  );

  // pixel setup values
  logic [7:0] wx_adj, xpos_in, ypos_in;
  assign wx_adj  = wx - 8'd7;
  assign ypos_in = win_act ? (cur_line - wy) : (scy + cur_line);
  assign xpos_in = (win_act && (req.column >= wx_adj)) ? (req.column - wx_adj)
                                                       : (scx + req.column);

  // background fetch addresses
  logic               map_sel;
  logic [VRAM_AW-1:0] map_addr, tile_addr;
  logic [7:0]         tile_id;
  assign map_sel  = win_act ? lcdc[6] : lcdc[3];
  assign map_addr = (map_sel ? MAP1_BASE : MAP0_BASE)
                    + {3'b0, ypos[7:3], 5'b0} + {8'b0, xpos[7:3]};
  assign tile_id  = lcdc[4] ? vram_rdata : (vram_rdata ^ TILE_FLIP);
  assign tile_addr = (lcdc[4] ? '0 : SIGNED_BASE)
                     + {1'b0, tile_id, 4'b0} + {9'b0, ypos[2:0], 1'b0};

  // current kept object
  logic [31:0]        cur_obj;
  logic [7:0]         o_y, o_x, o_tid, o_attr;
  logic               o_cover;
  logic [2:0]         o_relx, o_rely;
  logic [VRAM_AW-1:0] o_addr;
  logic               o_more;
  assign cur_obj = line_objs[obj_idx[LIW-1:0]];
  assign o_y     = cur_obj[7:0];
  assign o_x     = cur_obj[15:8];
  assign o_tid   = cur_obj[23:16];
  assign o_attr  = cur_obj[31:24];
  assign o_cover = (({1'b0, px} + OBJ_X_OFS) >= {1'b0, o_x}) && (px < o_x);
  assign o_relx  = o_attr[5] ? ~(px[2:0] - o_x[2:0]) : (px[2:0] - o_x[2:0]);
  assign o_rely  = o_attr[6] ? ~(cur_line[2:0] - o_y[2:0])
                             : (cur_line[2:0] - o_y[2:0]);
  assign o_addr  = (o_attr[3] ? OBJ_BANK_BASE : '0)
                   + {1'b0, o_tid, 4'b0} + {9'b0, o_rely, 1'b0};
  assign o_more  = obj_idx < obj_cnt;

  // colors
  logic [1:0] bg_now, obj_color, obj_shade, bg_shade;
  logic       obj_wins;
  logic [7:0] obj_pal;
  assign bg_now    = {vram_rdata[~xpos[2:0]], lo_byte[~xpos[2:0]]};
  assign obj_color = {vram_rdata[~obj_relx], lo_byte[~obj_relx]};
  assign obj_wins  = !obj_attr[7] || (bg == 2'd0);
  assign obj_pal   = (obj_attr[4] ? obp1 : obp0) & 8'hfc;
  assign obj_shade = obj_pal[{obj_color, 1'b0} +: 2];
  assign bg_shade  = bgp[{bg, 1'b0} +: 2];

  // object table scan
  logic       scan_cover, scan_last, scan_full;
  logic [8:0] line9;
  assign line9      = {1'b0, cur_line};
  assign scan_cover = ((line9 + OBJ_Y_OFS) >= {1'b0, scan_word[7:0]})
                      && ((line9 + OBJ_X_OFS) < {1'b0, scan_word[7:0]});
  assign scan_last  = ({1'b0, scan_idx} == (OIW + 1)'(NUM_OBJ - 1));
  assign scan_full  = scan_cover && (obj_cnt == CW'(MAX_LINE_OBJECTS - 1));

  logic can_emit;
  assign can_emit  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next = state;
    vram_raddr = map_addr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.func == FN_LINE) begin
            state_next = lcdc[1] ? ST_SCAN_RD : ST_IDLE;
          end else if (req.func == FN_PIXEL
                       && ({1'b0, req.column} < 9'(LINE_WIDTH))) begin
            state_next = ST_MAP;
          end
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_CAP;
      ST_SCAN_CAP: begin
        if (scan_byte == 2'd3 && (scan_last || scan_full)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_MAP: state_next = ST_TLO;
      ST_TLO: begin
        vram_raddr = tile_addr;
        state_next = ST_THI;
      end
      ST_THI: begin
        vram_raddr = row_addr + 13'd1;
        state_next = ST_BG;
      end
      ST_BG: state_next = ST_OBJ;
      ST_OBJ: begin
        vram_raddr = o_addr;
        if (!o_more) begin
          state_next = ST_EMIT;
        end else if (o_cover) begin
          state_next = ST_OLO;
        end
      end
      ST_OLO: begin
        vram_raddr = row_addr + 13'd1;
        state_next = ST_OHI;
      end
      ST_OHI: state_next = (obj_color == 2'd0) ? ST_OBJ : ST_EMIT;
      ST_EMIT: begin
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line  <= '0;
      win_act   <= 1'b0;
      obj_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept && req.func == FN_LINE) begin
        cur_line <= req.line;
        win_act  <= lcdc[5] && (wy <= req.line);
        obj_cnt  <= '0;
      end else if (state == ST_SCAN_CAP && scan_byte == 2'd3 && scan_cover) begin
        obj_cnt <= obj_cnt + CW'(1);
      end
      if (state == ST_EMIT && can_emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx  <= '0;
      scan_byte <= '0;
      px        <= req.column;
      xpos      <= xpos_in;
      ypos      <= ypos_in;
      obj_idx   <= '0;
    end
    case (state)
      ST_SCAN_CAP: begin
        scan_byte <= scan_byte + 2'd1;
        if (scan_byte == 2'd3) begin
          scan_idx <= scan_idx + OIW'(1);
          if (scan_cover) begin
            line_objs[obj_cnt[LIW-1:0]] <= {oam_rdata, scan_word};
          end
        end else begin
          scan_word[{scan_byte, 3'b0} +: 8] <= oam_rdata;
        end
      end
      ST_TLO: row_addr <= tile_addr;
      ST_THI: lo_byte  <= vram_rdata;
      ST_BG:  bg       <= bg_now;
      ST_OBJ: begin
        row_addr <= o_addr;
        obj_relx <= o_relx;
        obj_attr <= o_attr;
        if (!o_more) begin
          res_shade <= bg_shade;
          res_obj   <= 1'b0;
        end else if (!o_cover) begin
          obj_idx <= obj_idx + CW'(1);
        end
      end
      ST_OLO: lo_byte <= vram_rdata;
      ST_OHI: begin
        if (obj_color == 2'd0) begin
          obj_idx <= obj_idx + CW'(1);
        end else begin
          res_shade <= obj_wins ? obj_shade : bg_shade;
          res_obj   <= obj_wins;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          out_shade <= res_shade;
          out_col   <= px;
          out_obj   <= res_obj;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.shade        = out_shade;
  assign rsp.pixel_column = out_col;
  assign rsp.from_object  = out_obj;

endmodule

`default_nettype wire

>>> rtl/tsr_ram.sv
// ----------------------------------------------------------------------------
// tsr_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
